### hw/rtl/mbdf_pkg.sv
// ----------------------------------------------------------------------------
// mbdf_pkg
// Shared types and constants for the multi-byte delimiter framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbdf_pkg;

	// Default sizing
	localparam int unsigned MAX_FRAME_DEF     = 4096;
	localparam int unsigned MAX_DELIMITER_DEF = 8;

	// Fixed field widths
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned DELIM_W     = 64;
	localparam int unsigned DLEN_W      = 4;
	localparam int unsigned FLEN_W      = 13;
	localparam int unsigned CFG_INDEX_W = 2;

	// Register reset values
	localparam logic [DELIM_W-1:0] DELIM_RESET = 64'd10;
	localparam logic [DLEN_W-1:0]  DLEN_RESET  = 4'd1;

	// Register indexes on the config port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DELIM_BYTES  = 2'd0,
		REG_DELIM_LENGTH = 2'd1
	} reg_index_t;

	// Current register contents
	typedef struct packed {
		logic [DELIM_W-1:0] delim_bytes;
		logic [DLEN_W-1:0]  delim_len;
	} cfg_t;

	// Frame decision for one byte
	typedef struct packed {
		logic              last;
		logic              ovf;
		logic [FLEN_W-1:0] length;
	} frame_res_t;

endpackage

`default_nettype wire

### hw/rtl/mbdf_cfg.sv
// ----------------------------------------------------------------------------
// mbdf_cfg
// Configuration register file: delimiter sequence and delimiter length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdf_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mbdf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [mbdf_pkg::DELIM_W-1:0]        cfg_data,
	output mbdf_pkg::cfg_t                           cfg
);

	mbdf_pkg::cfg_t cfg_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim_bytes <= mbdf_pkg::DELIM_RESET;
			cfg_q.delim_len   <= mbdf_pkg::DLEN_RESET;
		end else if (cfg_valid) begin
			unique case (mbdf_pkg::reg_index_t'(cfg_index))
				mbdf_pkg::REG_DELIM_BYTES: begin
					cfg_q.delim_bytes <= cfg_data;
				end
				mbdf_pkg::REG_DELIM_LENGTH: begin
					cfg_q.delim_len <= cfg_data[mbdf_pkg::DLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mbdf_frame.sv
// ----------------------------------------------------------------------------
// mbdf_frame
// Frame state (byte history, frame count) and the per-byte delimiter match.
// ----------------------------------------------------------------------------
`default_nettype none

module mbdf_frame #(
	parameter int unsigned MAX_FRAME     = mbdf_pkg::MAX_FRAME_DEF,
	parameter int unsigned MAX_DELIMITER = mbdf_pkg::MAX_DELIMITER_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic [mbdf_pkg::BYTE_W-1:0]   byte_s1,
	input  mbdf_pkg::cfg_t                     cfg,
	output mbdf_pkg::frame_res_t               res
);

	localparam int unsigned HIST_W = MAX_DELIMITER * mbdf_pkg::BYTE_W;
	localparam int unsigned CNT_W  = $clog2(MAX_FRAME + 1);

	logic [HIST_W-1:0]                   hist_q;
	logic [CNT_W-1:0]                    count_q;
	logic [HIST_W-1:0]                   hist_nxt;
	logic [CNT_W-1:0]                    count_nxt;
	logic [mbdf_pkg::DLEN_W-1:0]         eff_len;
	logic [MAX_DELIMITER-1:0]            hit_vec;
	logic                                hit;
	logic                                ovf;
	logic [CNT_W+mbdf_pkg::FLEN_W-1:0]   count_ext;

	// Clamp length to 1..MAX_DELIMITER
	always_comb begin
		eff_len = cfg.delim_len;
		if (eff_len == '0) begin
			eff_len = mbdf_pkg::DLEN_W'(1);
		end
		if (eff_len > mbdf_pkg::DLEN_W'(MAX_DELIMITER)) begin
			eff_len = mbdf_pkg::DLEN_W'(MAX_DELIMITER);
		end
	end

	// History with the new byte shifted in, newest byte at the bottom
	assign hist_nxt  = (hist_q << mbdf_pkg::BYTE_W) | HIST_W'(byte_s1);
	assign count_nxt = count_q + CNT_W'(1);

	// One comparator set per candidate length; delimiter byte 0 is oldest
	always_comb begin
		hit_vec = '0;
		for (int l = 1; l <= int'(MAX_DELIMITER); l++) begin
			hit_vec[l-1] = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (cfg.delim_bytes[8*i +: 8] != hist_nxt[8*(l-1-i) +: 8]) begin
					hit_vec[l-1] = 1'b0;
				end
			end
		end
	end

	// Pick the active length; the frame must already hold that many bytes
	always_comb begin
		hit = 1'b0;
		for (int l = 1; l <= int'(MAX_DELIMITER); l++) begin
			if (eff_len == mbdf_pkg::DLEN_W'(l)) begin
				hit = hit_vec[l-1];
			end
		end
		hit = hit && (count_nxt >= CNT_W'(eff_len));
	end

	assign ovf       = !hit && (count_nxt >= CNT_W'(MAX_FRAME));
	assign count_ext = (CNT_W + mbdf_pkg::FLEN_W)'(count_nxt);

	assign res.last   = hit || ovf;
	assign res.ovf    = ovf;
	assign res.length = count_ext[mbdf_pkg::FLEN_W-1:0];

	// State update when the byte moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			hist_q  <= hist_nxt;
			count_q <= res.last ? '0 : count_nxt;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/multi_byte_delimiter_framer.sv
// ----------------------------------------------------------------------------
// multi_byte_delimiter_framer
// Cuts a byte stream into frames ended by a configurable 1..8 byte delimiter.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with data_byte, one byte per word.
// Output channel: out_valid / out_stall with byte_out, frame_last,
// frame_length and overflow; one output word per input word, in order.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// delimiter_bytes (0) or delimiter_length (1); other indexes are ignored.
// Write config only while no word is in flight.
// Path: an accepted byte lands in the input register, then moves with its
// frame decision into the output register once that is free.
// Throughput: one byte per cycle while the output is not stalled; the
// match is a parallel compare over the byte history, one comparator set
// per delimiter length.
// Reset: clears history, frame count and both valid flags; the delimiter
// becomes a single line feed.
// Stall: a stalled output word holds; the input register still fills once,
// then in_stall rises until the output word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_byte_delimiter_framer #(
	parameter int unsigned MAX_FRAME     = mbdf_pkg::MAX_FRAME_DEF,
	parameter int unsigned MAX_DELIMITER = mbdf_pkg::MAX_DELIMITER_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input bytes
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [mbdf_pkg::BYTE_W-1:0]        data_byte,
	// framed bytes
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [mbdf_pkg::BYTE_W-1:0]             byte_out,
	output logic                                    frame_last,
	output logic [mbdf_pkg::FLEN_W-1:0]             frame_length,
	output logic                                    overflow,
	// config writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mbdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [mbdf_pkg::DELIM_W-1:0]       cfg_data
);

	mbdf_pkg::cfg_t                  cfg;
	mbdf_pkg::frame_res_t            res;
	logic                            valid_s1;
	logic [mbdf_pkg::BYTE_W-1:0]     byte_s1;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            advance;
	logic                            in_take;

	mbdf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbdf_frame #(
		.MAX_FRAME     (MAX_FRAME),
		.MAX_DELIMITER (MAX_DELIMITER)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Handshake glue
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_out     <= byte_s1;
			frame_last   <= res.last;
			frame_length <= res.length;
			overflow     <= res.ovf;
		end
	end

endmodule

`default_nettype wire
